[rtl/hypo_pkg.sv]
// Shared types, constants and helper functions of the hypotrochoid point generator.
// Depends on nothing; every other file refers to it by scoped names.
package hypo_pkg;

	localparam int INT_FRAC = 30;

	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] GAIN_Q30    = 64'd652032874;

	localparam logic [31:0] PEN_RESET    = 32'd65536;
	localparam logic [31:0] RADIUS_RESET = 32'd16384;

	// Register indexes of the configuration port.
	localparam logic CFG_PEN    = 1'b0;
	localparam logic CFG_RADIUS = 1'b1;

	typedef struct packed {
		logic               busy;
		logic               err;
		logic               sat;
		logic signed [31:0] omk;
		logic signed [31:0] lk;
		logic signed [31:0] ratio;
	} cfg_t;

	typedef struct packed {
		logic               sat;
		logic signed [31:0] val;
	} sat_t;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.sat = 1'b1;
			r.val = 32'sh7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			r.sat = 1'b1;
			r.val = 32'sh8000_0000;
		end else begin
			r.sat = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

	// Arctangent of 2^-i with 30 fraction bits.
	function automatic logic [31:0] atan_q30(input int unsigned idx);
		logic [31:0] r;
		case (idx)
			0: r = 32'd843314857;
			1: r = 32'd497837829;
			2: r = 32'd263043837;
			3: r = 32'd133525159;
			4: r = 32'd67021687;
			5: r = 32'd33543516;
			6: r = 32'd16775851;
			7: r = 32'd8388437;
			8: r = 32'd4194283;
			9: r = 32'd2097149;
			10: r = 32'd1048576;
			11: r = 32'd524288;
			12: r = 32'd262144;
			13: r = 32'd131072;
			14: r = 32'd65536;
			15: r = 32'd32768;
			16: r = 32'd16384;
			17: r = 32'd8192;
			18: r = 32'd4096;
			19: r = 32'd2048;
			20: r = 32'd1024;
			21: r = 32'd512;
			22: r = 32'd256;
			23: r = 32'd128;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/hypotrochoid_point.sv]
// Hypotrochoid point generator: one angle in, one (x, y) point out.
// Results pass through the top-level stages, the angle reduction stages and the CORDIC
// stages; throughput is one request per cycle while the output is not stalled.
// After any configuration write, and after reset, requests wait while the divider forms
// (1-k)/k. Reset is asynchronous and active low; it empties the pipeline and loads
// l = 1.0 and k = 0.25. Uses hypo_pkg.
module hypotrochoid_point #(
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               angle_valid,
	output logic               angle_ready,
	input  logic signed [31:0] angle,
	output logic               point_valid,
	input  logic               point_ready,
	output logic signed [31:0] x_coord,
	output logic signed [31:0] y_coord,
	output logic               error_flag,
	output logic               saturated_flag
);

	localparam int QB      = 30 - FRAC_BITS;
	localparam int RED_LAT = QB + 2;
	localparam int MID     = RED_LAT + CORDIC_STAGES;
	localparam int LAT     = MID + 4;

	hypo_pkg::cfg_t cfg;
	logic           en;
	logic           take;
	logic           vld_s [1:LAT];

	// Top-level stages: s1 multiply, s2 round, then reduction and CORDIC, s3 products, s4 sum.
	logic signed [63:0] prod_s1;
	logic signed [31:0] ang_s1;
	logic signed [31:0] t2_s2;
	logic signed [31:0] ang_s2;
	logic               tsat_s2;
	logic               sat_d_s [1:MID];

	hypo_pkg::sat_t t2_w;
	logic signed [33:0] z1;
	logic signed [33:0] z2;
	logic               n1;
	logic               n2;
	logic signed [32:0] c1;
	logic signed [32:0] s1;
	logic signed [32:0] c2;
	logic signed [32:0] s2;
	logic               cn1;
	logic               cn2;
	logic signed [32:0] c1n;
	logic signed [32:0] s1n;
	logic signed [32:0] c2n;
	logic signed [32:0] s2n;

	logic signed [64:0] pc1_s3;
	logic signed [64:0] ps1_s3;
	logic signed [64:0] pc2_s3;
	logic signed [64:0] ps2_s3;
	logic               sat_s3;

	logic signed [63:0] xr;
	logic signed [63:0] yr;
	hypo_pkg::sat_t     xs;
	hypo_pkg::sat_t     ys;
	logic signed [31:0] x_s4;
	logic signed [31:0] y_s4;
	logic               err_s4;
	logic               sat_s4;

	localparam logic signed [64:0] RND30 = 65'sd1 <<< (hypo_pkg::INT_FRAC - 1);

	hypo_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The whole pipeline moves whenever the output slot is free or being emptied.
	assign en          = !vld_s[LAT] || point_ready;
	assign angle_ready = en && !cfg.busy;
	assign take        = angle_valid && angle_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= take;
			for (int i = 2; i <= LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	assign t2_w = hypo_pkg::sat32((prod_s1 + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= cfg.ratio * angle;
			ang_s1  <= angle;
			t2_s2   <= t2_w.val;
			tsat_s2 <= t2_w.sat;
			ang_s2  <= ang_s1;
			sat_d_s[1] <= tsat_s2;
			for (int i = 2; i <= MID; i++) begin
				sat_d_s[i] <= sat_d_s[i-1];
			end
		end
	end

	hypo_reduce #(.FRAC_BITS(FRAC_BITS)) u_red1 (
		.clk (clk), .en (en), .ang (ang_s2), .z (z1), .neg (n1)
	);

	hypo_reduce #(.FRAC_BITS(FRAC_BITS)) u_red2 (
		.clk (clk), .en (en), .ang (t2_s2), .z (z2), .neg (n2)
	);

	hypo_cordic #(.STAGES(CORDIC_STAGES)) u_cordic1 (
		.clk (clk), .en (en), .z_in (z1), .neg_in (n1),
		.cos_out (c1), .sin_out (s1), .neg_out (cn1)
	);

	hypo_cordic #(.STAGES(CORDIC_STAGES)) u_cordic2 (
		.clk (clk), .en (en), .z_in (z2), .neg_in (n2),
		.cos_out (c2), .sin_out (s2), .neg_out (cn2)
	);

	always_comb begin
		c1n = cn1 ? -c1 : c1;
		s1n = cn1 ? -s1 : s1;
		c2n = cn2 ? -c2 : c2;
		s2n = cn2 ? -s2 : s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc1_s3 <= cfg.omk * c1n;
			ps1_s3 <= cfg.omk * s1n;
			pc2_s3 <= cfg.lk * c2n;
			ps2_s3 <= cfg.lk * s2n;
			sat_s3 <= sat_d_s[MID];
		end
	end

	always_comb begin
		xr = 64'((pc1_s3 + RND30) >>> hypo_pkg::INT_FRAC)
			+ 64'((pc2_s3 + RND30) >>> hypo_pkg::INT_FRAC);
		yr = 64'((ps1_s3 + RND30) >>> hypo_pkg::INT_FRAC)
			- 64'((ps2_s3 + RND30) >>> hypo_pkg::INT_FRAC);
		xs = hypo_pkg::sat32(xr);
		ys = hypo_pkg::sat32(yr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cfg.err) begin
				x_s4   <= '0;
				y_s4   <= '0;
				err_s4 <= 1'b1;
				sat_s4 <= 1'b0;
			end else begin
				x_s4   <= xs.val;
				y_s4   <= ys.val;
				err_s4 <= 1'b0;
				sat_s4 <= sat_s3 | cfg.sat | xs.sat | ys.sat;
			end
		end
	end

	assign point_valid    = vld_s[LAT];
	assign x_coord        = x_s4;
	assign y_coord        = y_s4;
	assign error_flag     = err_s4;
	assign saturated_flag = sat_s4;

	// No request is taken while the derived shape values are being recomputed.
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.busy |-> !angle_ready)
		else $error("request accepted while configuration is busy");

	// A waiting result freezes the pipeline valid bits.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !point_ready) |=> $stable(vld_s[1]) && point_valid)
		else $error("pipeline moved under a stalled result");

	// An error point is all zero and never marked as clamped.
	a_err_point: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && error_flag) |-> (x_coord == 32'sd0 && y_coord == 32'sd0
			&& !saturated_flag))
		else $error("error point is not zero");

	// An accepted request enters the first pipeline stage when the output is not stalled.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(take && point_ready) |=> vld_s[1])
		else $error("accepted request did not enter the pipeline");

endmodule

[rtl/hypo_cfg.sv]
// Shape registers and the values derived from them: 1-k, l*k and the ratio (1-k)/k.
// The ratio comes from a one-bit-per-cycle restoring divider. Uses hypo_pkg.
module hypo_cfg #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	output hypo_pkg::cfg_t    cfg
);

	localparam int DW = 32 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);
	localparam logic [DW-1:0] LIM = DW'(64'h8000_0000);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]         state_q;
	logic signed [31:0] pen_q;
	logic signed [31:0] radius_q;
	logic [CW-1:0]      cnt_q;
	logic [DW-1:0]      num_q;
	logic [DW-1:0]      quo_q;
	logic [31:0]        rem_q;
	logic [31:0]        den_q;
	logic               neg_q;
	logic signed [31:0] omk_q;
	logic signed [31:0] lk_q;
	logic signed [31:0] ratio_q;
	logic               sat_q;

	logic signed [63:0] omk_wide;
	logic signed [63:0] lk_prod;
	hypo_pkg::sat_t     omk_w;
	hypo_pkg::sat_t     lk_w;
	logic [31:0]        omk_abs;
	logic [31:0]        k_abs;
	logic [32:0]        trial;
	logic               fits;

	always_comb begin
		omk_wide = (64'sd1 <<< FRAC_BITS) - 64'(radius_q);
		omk_w    = hypo_pkg::sat32(omk_wide);
		lk_prod  = pen_q * radius_q;
		lk_w     = hypo_pkg::sat32((lk_prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
		omk_abs  = omk_w.val[31] ? 32'(-omk_w.val) : 32'(omk_w.val);
		k_abs    = radius_q[31] ? 32'(-radius_q) : 32'(radius_q);
		trial    = {rem_q, num_q[DW-1]};
		fits     = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_PREP;
			pen_q    <= hypo_pkg::PEN_RESET;
			radius_q <= hypo_pkg::RADIUS_RESET;
			cnt_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hypo_pkg::CFG_PEN:    pen_q    <= cfg_data;
				hypo_pkg::CFG_RADIUS: radius_q <= cfg_data;
				default: ;
			endcase
			state_q <= ST_PREP;
		end else begin
			unique case (state_q)
				ST_PREP: begin
					cnt_q   <= CW'(DW);
					state_q <= (radius_q == 32'sd0) ? ST_IDLE : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_PREP: begin
				omk_q <= omk_w.val;
				lk_q  <= lk_w.val;
				sat_q <= omk_w.sat | lk_w.sat;
				num_q <= {omk_abs, {FRAC_BITS{1'b0}}};
				rem_q <= '0;
				quo_q <= '0;
				den_q <= k_abs;
				neg_q <= omk_w.val[31] ^ radius_q[31];
			end
			ST_DIV: begin
				rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
				num_q <= {num_q[DW-2:0], 1'b0};
				quo_q <= {quo_q[DW-2:0], fits};
			end
			ST_DONE: begin
				if (neg_q) begin
					if (quo_q > LIM) begin
						ratio_q <= 32'sh8000_0000;
						sat_q   <= 1'b1;
					end else begin
						ratio_q <= 32'(-quo_q[31:0]);
					end
				end else if (quo_q > LIM - 1'b1) begin
					ratio_q <= 32'sh7fff_ffff;
					sat_q   <= 1'b1;
				end else begin
					ratio_q <= quo_q[31:0];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		cfg.busy  = state_q != ST_IDLE;
		cfg.err   = radius_q == 32'sd0;
		cfg.sat   = sat_q;
		cfg.omk   = omk_q;
		cfg.lk    = lk_q;
		cfg.ratio = ratio_q;
	end

endmodule

[rtl/hypo_reduce.sv]
// Angle reduction: t * 2^(30-FRAC_BITS) modulo 2pi into [-pi, pi), then folded into
// [-pi/2, pi/2] with a negate mark. One compare-subtract per stage. Uses hypo_pkg.
module hypo_reduce #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] ang,
	output logic signed [33:0] z,
	output logic               neg
);

	localparam int QB = 30 - FRAC_BITS;
	localparam int W  = 63 - FRAC_BITS;
	localparam logic [W-1:0] C   = W'(hypo_pkg::TWO_PI_Q30);
	localparam logic [W-1:0] PIW = W'(hypo_pkg::PI_Q30);
	// A multiple of 2pi larger than any angle keeps the dividend positive.
	localparam logic [W-1:0] OFS = (C << (29 - FRAC_BITS)) + PIW;
	localparam logic signed [33:0] PI34   = 34'(hypo_pkg::PI_Q30);
	localparam logic signed [33:0] HALF34 = 34'(hypo_pkg::HALF_PI_Q30);

	logic [W-1:0]       rem_s [0:QB];
	logic signed [33:0] fold_z_s;
	logic               fold_neg_s;
	logic [W-1:0]       shifted;
	logic signed [33:0] r;

	assign shifted = W'({{(W-32){ang[31]}}, ang}) << QB;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= shifted + OFS;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_step
		localparam logic [W-1:0] D = C << (QB - j);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= (rem_s[j-1] >= D) ? rem_s[j-1] - D : rem_s[j-1];
			end
		end
	end

	assign r = $signed(34'(rem_s[QB])) - PI34;

	always_ff @(posedge clk) begin
		if (en) begin
			if (r > HALF34) begin
				fold_z_s   <= r - PI34;
				fold_neg_s <= 1'b1;
			end else if (r < -HALF34) begin
				fold_z_s   <= r + PI34;
				fold_neg_s <= 1'b1;
			end else begin
				fold_z_s   <= r;
				fold_neg_s <= 1'b0;
			end
		end
	end

	assign z   = fold_z_s;
	assign neg = fold_neg_s;

endmodule

[rtl/hypo_cordic.sv]
// Rotation-mode CORDIC, one micro-rotation per register stage, Q30 vectors.
// Carries the fold mark alongside. Uses hypo_pkg for the gain and arctangent table.
module hypo_cordic #(
	parameter int STAGES = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] z_in,
	input  logic               neg_in,
	output logic signed [32:0] cos_out,
	output logic signed [32:0] sin_out,
	output logic               neg_out
);

	logic signed [32:0] x_s [1:STAGES];
	logic signed [32:0] y_s [1:STAGES];
	logic signed [33:0] z_s [1:STAGES];
	logic               neg_s [1:STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		localparam logic signed [33:0] ANG = 34'(hypo_pkg::atan_q30(i));
		logic signed [32:0] xp;
		logic signed [32:0] yp;
		logic signed [33:0] zp;
		logic               np;
		if (i == 0) begin : g_first
			assign xp = 33'(hypo_pkg::GAIN_Q30);
			assign yp = '0;
			assign zp = z_in;
			assign np = neg_in;
		end else begin : g_next
			assign xp = x_s[i];
			assign yp = y_s[i];
			assign zp = z_s[i];
			assign np = neg_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zp[33]) begin
					x_s[i+1] <= xp - (yp >>> i);
					y_s[i+1] <= yp + (xp >>> i);
					z_s[i+1] <= zp - ANG;
				end else begin
					x_s[i+1] <= xp + (yp >>> i);
					y_s[i+1] <= yp - (xp >>> i);
					z_s[i+1] <= zp + ANG;
				end
				neg_s[i+1] <= np;
			end
		end
	end

	assign cos_out = x_s[STAGES];
	assign sin_out = y_s[STAGES];
	assign neg_out = neg_s[STAGES];

endmodule
